// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL files.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check, disabled while reset is asserted
`define ASSERT_CLK(label, clk_s, rst_s, prop) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("assertion failed");
// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk_s, prop) \
    label: assert property (@(posedge clk_s) prop) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk_s, rst_s, prop)
`define ASSERT_ALWAYS(label, clk_s, prop)
`endif
`endif

// ===== sv/tuc_pkg.sv =====
// Shared types and constants for the text unit cleaner.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tuc_pkg;

    // Field widths
    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned RUN_W   = 8;
    localparam int unsigned COUNT_W = 2;

    // APB configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Register index of single_byte_mode
    localparam logic REG_SINGLE_BYTE_MODE = 1'b0;

    typedef logic [UNIT_W-1:0]  unit_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [RUN_W-1:0]   run_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Special codes
    localparam unit_t CODE_CR        = 16'h000D;
    localparam unit_t CODE_VT        = 16'h000B;
    localparam unit_t CODE_BEL       = 16'h0007;
    localparam unit_t CODE_SPACE     = 16'h0020;
    localparam unit_t CODE_ASCII_MAX = 16'h007E;
    localparam unit_t CODE_NON_ASCII = 16'h0080;
    localparam unit_t CODE_3BYTE_MIN = 16'h0800;

    localparam byte_t BYTE_TAB       = 8'h09;
    localparam byte_t LEAD_2BYTE     = 8'hC0;
    localparam byte_t LEAD_3BYTE     = 8'hE0;
    localparam byte_t CONT_MARK      = 8'h80;
    localparam byte_t CONT_MASK      = 8'h3F;

    // Byte counts
    localparam count_t CNT_NONE  = 2'd0;
    localparam count_t CNT_ONE   = 2'd1;
    localparam count_t CNT_TWO   = 2'd2;
    localparam count_t CNT_THREE = 2'd3;

    // Classification of one unit
    typedef struct packed {
        logic   is_nl;
        count_t n;
        byte_t  b0;
        byte_t  b1;
        byte_t  b2;
    } enc_t;

    function automatic enc_t classify(input unit_t code, input logic narrow);
        unit_t u;
        enc_t  e;
        u = narrow ? {8'h00, code[7:0]} : code;
        e = '0;
        if (u == CODE_CR || u == CODE_VT) begin
            e.is_nl = 1'b1;
        end else if (u == CODE_BEL) begin
            e.b0 = BYTE_TAB;
            e.n  = CNT_ONE;
        end else if (narrow) begin
            if (u >= CODE_SPACE) begin
                e.b0 = u[7:0];
                e.n  = CNT_ONE;
            end
        end else if (u >= CODE_SPACE && u <= CODE_ASCII_MAX) begin
            e.b0 = u[7:0];
            e.n  = CNT_ONE;
        end else if (u >= CODE_NON_ASCII) begin
            if (u < CODE_3BYTE_MIN) begin
                e.b0 = LEAD_2BYTE | {3'b000, u[10:6]};
                e.b1 = CONT_MARK | (u[7:0] & CONT_MASK);
                e.n  = CNT_TWO;
            end else begin
                e.b0 = LEAD_3BYTE | {4'h0, u[15:12]};
                e.b1 = CONT_MARK | ({2'b00, u[11:6]} & CONT_MASK);
                e.b2 = CONT_MARK | (u[7:0] & CONT_MASK);
                e.n  = CNT_THREE;
            end
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tuc_unit_if.sv =====
// Input channel: one text code unit per request.
// Depends on tuc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tuc_unit_if;
    logic            valid;
    logic            ready;
    tuc_pkg::unit_t  code_unit;
    logic            last;

    modport source (output valid, output code_unit, output last, input ready);
    modport sink   (input valid, input code_unit, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/tuc_result_if.sv =====
// Result channel: newline run plus up to three output bytes per request.
// Depends on tuc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tuc_result_if;
    logic             valid;
    logic             ready;
    tuc_pkg::run_t    newline_run;
    tuc_pkg::count_t  byte_count;
    tuc_pkg::byte_t   byte0;
    tuc_pkg::byte_t   byte1;
    tuc_pkg::byte_t   byte2;
    logic             done_res;

    modport source (output valid, output newline_run, output byte_count,
                    output byte0, output byte1, output byte2, output done_res,
                    input ready);
    modport sink   (input valid, input newline_run, input byte_count,
                    input byte0, input byte1, input byte2, input done_res,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/text_unit_cleaner_utf8_unit.sv =====
// Top level: text unit cleaner with UTF-8 output (raw bytes in single-byte mode) and APB mode register.
// Depends on tuc_pkg, tuc_unit_if, tuc_result_if and assert_macros.svh.
//
//   channel   | dir | handshake      | payload
//   ----------+-----+----------------+-----------------------------------------
//   unit_in   | in  | valid / ready  | code_unit, last
//   res_out   | out | valid / ready  | newline_run, byte_count, byte0..2, done_res
//   apb       | in  | psel / penable | paddr, pwdata, pwrite -> prdata, pready
//
// One unit is accepted per cycle unless the input register is stalled.
// A unit is classified in the input register, where the pending newline count
// is updated; a result (if any) then sits in the output register.
// A stalled output register holds only units that produce a result; dropped
// units and newlines keep flowing. Reset clears the mode, the pending count
// and both valid flags; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module text_unit_cleaner_utf8_unit #(
    parameter int unsigned MAX_PENDING = 255
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // APB configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tuc_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [tuc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [tuc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready,
    // Streams
    tuc_unit_if.sink                                unit_in,
    tuc_result_if.source                            res_out
);

    // Saturation limit of the pending count
    localparam tuc_pkg::run_t NL_CAP =
        (MAX_PENDING < 255) ? tuc_pkg::run_t'(MAX_PENDING) : 8'd255;

    // Configuration register
    logic mode_reg;
    logic cfg_wr;

    // Input stage
    logic            s1_valid_reg;
    tuc_pkg::unit_t  s1_code_reg;
    logic            s1_last_reg;

    // Pending newlines
    tuc_pkg::run_t   pend_reg;
    tuc_pkg::run_t   pend_next;

    // Output stage
    logic            out_valid_reg;
    logic            out_valid_next;
    tuc_pkg::run_t   out_run_reg;
    tuc_pkg::count_t out_cnt_reg;
    tuc_pkg::byte_t  out_b0_reg;
    tuc_pkg::byte_t  out_b1_reg;
    tuc_pkg::byte_t  out_b2_reg;
    logic            out_done_reg;

    tuc_pkg::enc_t   enc;
    logic            has_result;
    logic            out_free;
    logic            s1_go;
    logic            load_out;
    logic            in_take;

    // APB access: writes land on the access cycle
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[tuc_pkg::APB_ADDR_W-1] == tuc_pkg::REG_SINGLE_BYTE_MODE);
    assign prdata = (paddr[tuc_pkg::APB_ADDR_W-1] == tuc_pkg::REG_SINGLE_BYTE_MODE)
                    ? {{(tuc_pkg::APB_DATA_W-1){1'b0}}, mode_reg}
                    : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            mode_reg <= pwdata[0];
        end
    end

    // Classify the registered unit
    assign enc        = tuc_pkg::classify(s1_code_reg, mode_reg);
    assign has_result = (enc.n != tuc_pkg::CNT_NONE) || s1_last_reg;
    assign out_free   = !out_valid_reg || res_out.ready;
    assign s1_go      = s1_valid_reg && (!has_result || out_free);
    assign load_out   = s1_go && has_result;

    assign unit_in.ready = !s1_valid_reg || s1_go;
    assign in_take       = unit_in.valid && unit_in.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (unit_in.ready)
        begin
            s1_valid_reg <= unit_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_code_reg <= unit_in.code_unit;
            s1_last_reg <= unit_in.last;
        end
    end

    // Pending count: cleared by any result, raised by a newline
    always_comb
    begin
        pend_next = pend_reg;
        if (s1_go)
        begin
            if (has_result)
            begin
                pend_next = '0;
            end
            else if (enc.is_nl && pend_reg < NL_CAP)
            begin
                pend_next = pend_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_run_reg  <= (enc.n != tuc_pkg::CNT_NONE) ? pend_reg : '0;
            out_cnt_reg  <= enc.n;
            out_b0_reg   <= enc.b0;
            out_b1_reg   <= enc.b1;
            out_b2_reg   <= enc.b2;
            out_done_reg <= s1_last_reg;
        end
    end

    assign res_out.valid       = out_valid_reg;
    assign res_out.newline_run = out_run_reg;
    assign res_out.byte_count  = out_cnt_reg;
    assign res_out.byte0       = out_b0_reg;
    assign res_out.byte1       = out_b1_reg;
    assign res_out.byte2       = out_b2_reg;
    assign res_out.done_res    = out_done_reg;

    // Checks
    `ASSERT_ALWAYS(a_pend_cap, clk, pend_reg <= NL_CAP)
    `ASSERT_CLK(a_empty_is_end, clk, rst_n,
        (out_valid_reg && out_cnt_reg == tuc_pkg::CNT_NONE)
            |-> (out_done_reg && out_run_reg == '0))
    `ASSERT_CLK(a_end_clears, clk, rst_n, (s1_go && s1_last_reg) |=> (pend_reg == '0))
    `ASSERT_CLK(a_unused_zero, clk, rst_n,
        (out_valid_reg && out_cnt_reg != tuc_pkg::CNT_THREE)
            |-> (out_b2_reg == '0 && (out_cnt_reg == tuc_pkg::CNT_TWO || out_b1_reg == '0)))

endmodule

`default_nettype wire
